// ----- design/sfd_pkg.sv -----
// Shared types, codes and the CRC-16/Modbus byte update for the frame deframer.
package sfd_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] SYNC_FIRST_RST = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] MAX_LEN_RST = 16'd1024;

  // CRC-16/Modbus constants
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT_FIRST,
    PH_HUNT_SECOND,
    PH_COMMAND,
    PH_LEN_LOW,
    PH_LEN_HIGH,
    PH_PAYLOAD,
    PH_CRC_LOW,
    PH_CRC_HIGH
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_CRC_ERROR = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_command;
    logic [15:0] frame_length;
    status_e     frame_status;
  } res_t;

  // Fold one byte into the running CRC, one bit per step
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/sfd_cfg_regs.sv -----
// Configuration registers: header bytes and largest payload length.
module sfd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfd_pkg::CfgDataW-1:0] cfg_data_i,
  output sfd_pkg::cfg_t                cfg_o
);

  sfd_pkg::cfg_t cfg_q;

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first <= sfd_pkg::SYNC_FIRST_RST;
      cfg_q.sync_second <= sfd_pkg::SYNC_SECOND_RST;
      cfg_q.max_len <= sfd_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfd_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first <= cfg_data_i[7:0];
        sfd_pkg::CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data_i[7:0];
        sfd_pkg::CFG_MAX_LEN:     cfg_q.max_len <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/sfd_parser.sv -----
// Frame parser: header hunt, field capture, CRC check and result building.
module sfd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  sfd_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output sfd_pkg::res_t res_o
);

  sfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  logic [15:0] crc_next;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  logic        too_long;
  logic        crc_match;

  assign crc_next = sfd_pkg::crc_update(
    (phase_q == sfd_pkg::PH_COMMAND) ? sfd_pkg::CRC_INIT : crc_q, byte_i);
  assign len_full = {byte_i, len_q[7:0]};
  assign cnt_inc = cnt_q + 16'd1;
  assign too_long = len_full > cfg_i.max_len;
  assign crc_match = {byte_i, crc_lo_q} == crc_q;

  // Next phase and holds
  always_comb begin
    phase_d = phase_q;
    cmd_d = cmd_q;
    len_d = len_q;
    cnt_d = cnt_q;
    crc_d = crc_q;
    crc_lo_d = crc_lo_q;
    if (step_i) begin
      case (phase_q)
        sfd_pkg::PH_HUNT_FIRST: begin
          if (byte_i == cfg_i.sync_first) phase_d = sfd_pkg::PH_HUNT_SECOND;
        end
        sfd_pkg::PH_HUNT_SECOND: begin
          phase_d = (byte_i == cfg_i.sync_second) ? sfd_pkg::PH_COMMAND
                                                  : sfd_pkg::PH_HUNT_FIRST;
        end
        sfd_pkg::PH_COMMAND: begin
          cmd_d = byte_i;
          crc_d = crc_next;
          phase_d = sfd_pkg::PH_LEN_LOW;
        end
        sfd_pkg::PH_LEN_LOW: begin
          len_d = {8'h00, byte_i};
          crc_d = crc_next;
          phase_d = sfd_pkg::PH_LEN_HIGH;
        end
        sfd_pkg::PH_LEN_HIGH: begin
          if (too_long) begin
            phase_d = sfd_pkg::PH_HUNT_FIRST;
          end else begin
            len_d = len_full;
            crc_d = crc_next;
            cnt_d = '0;
            phase_d = (len_full == '0) ? sfd_pkg::PH_CRC_LOW : sfd_pkg::PH_PAYLOAD;
          end
        end
        sfd_pkg::PH_PAYLOAD: begin
          crc_d = crc_next;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) phase_d = sfd_pkg::PH_CRC_LOW;
        end
        sfd_pkg::PH_CRC_LOW: begin
          crc_lo_d = byte_i;
          phase_d = sfd_pkg::PH_CRC_HIGH;
        end
        default: begin
          phase_d = sfd_pkg::PH_HUNT_FIRST;
        end
      endcase
      // Clear every hold on return to the hunt
      if (phase_d == sfd_pkg::PH_HUNT_FIRST) begin
        cmd_d = '0;
        len_d = '0;
        cnt_d = '0;
        crc_d = sfd_pkg::CRC_INIT;
        crc_lo_d = '0;
      end
    end
  end

  // Result of this byte
  always_comb begin
    res_valid_o = 1'b0;
    res_o.item_kind = sfd_pkg::KIND_PAYLOAD;
    res_o.payload_byte = '0;
    res_o.frame_command = cmd_q;
    res_o.frame_length = len_q;
    res_o.frame_status = sfd_pkg::ST_OK;
    case (phase_q)
      sfd_pkg::PH_LEN_HIGH: begin
        res_valid_o = step_i && too_long;
        res_o.item_kind = sfd_pkg::KIND_END;
        res_o.frame_length = len_full;
        res_o.frame_status = sfd_pkg::ST_TOO_LONG;
      end
      sfd_pkg::PH_PAYLOAD: begin
        res_valid_o = step_i;
        res_o.payload_byte = byte_i;
      end
      sfd_pkg::PH_CRC_HIGH: begin
        res_valid_o = step_i;
        res_o.item_kind = sfd_pkg::KIND_END;
        res_o.frame_status = crc_match ? sfd_pkg::ST_OK : sfd_pkg::ST_CRC_ERROR;
      end
      default: ;
    endcase
  end

  // Phase and hold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfd_pkg::PH_HUNT_FIRST;
      cmd_q <= '0;
      len_q <= '0;
      cnt_q <= '0;
      crc_q <= sfd_pkg::CRC_INIT;
      crc_lo_q <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q <= cmd_d;
      len_q <= len_d;
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

// ----- design/serial_frame_deframer_crc16_top.sv -----
// Top level of the framed byte receiver with CRC-16/Modbus check.
//
// Usage: received bytes enter on the input channel (in_valid_i, in_stall_o,
// rx_byte_i). The block hunts for the two configured header bytes, then
// reads command, little-endian length, payload and little-endian CRC.
// Each payload byte leaves as one request of kind payload on the output
// channel (out_valid_o, out_stall_i); the last CRC byte, or a length above
// max_len, leaves as one end request carrying the status. The
// consumer drops the payload of a frame that ends in crc_error.
// Path: an accepted byte is registered in the input register, passes the
// parse stage, and its request is registered in the result register.
// Throughput: one byte per cycle while the output is not stalled, set by
// the single parse stage between the input register and the result register.
// Reset: both registers empty, parser hunting, configuration at its reset
// values (0xAA, 0x55, 1024). Configuration is written through cfg_we_i.
// Stall: while the result register is full and stalled, the parse stage
// holds; a byte in the input register stays there and in_stall_o rises.
module serial_frame_deframer_crc16_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         item_kind_o,
  output logic [7:0]                   payload_byte_o,
  output logic [7:0]                   frame_command_o,
  output logic [15:0]                  frame_length_o,
  output logic [1:0]                   frame_status_o
);

  sfd_pkg::cfg_t cfg;
  sfd_pkg::res_t res;
  sfd_pkg::res_t out_q;
  logic          res_valid;
  logic          advance;
  logic          in_accept;
  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          out_valid_q;

  sfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the parse stage whenever the result register can take a request
  assign advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_valid_q && advance),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_kind_o = out_q.item_kind;
  assign payload_byte_o = out_q.payload_byte;
  assign frame_command_o = out_q.frame_command;
  assign frame_length_o = out_q.frame_length;
  assign frame_status_o = out_q.frame_status;

endmodule

// ----- design/sfd_checker.sv -----
// Port-level checks for the frame receiver, bound to the top level.
module sfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        item_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [7:0]  frame_command_o,
  input logic [15:0] frame_length_o,
  input logic [1:0]  frame_status_o
);

  // Hold a stalled result request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(item_kind_o) &&
      $stable(payload_byte_o) && $stable(frame_command_o) &&
      $stable(frame_length_o) && $stable(frame_status_o))
    else $error("stalled result request changed");

  // Payload requests carry no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == sfd_pkg::KIND_PAYLOAD |->
      frame_status_o == sfd_pkg::ST_OK)
    else $error("payload request with nonzero status");

  // End reports carry a zero payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == sfd_pkg::KIND_END |-> payload_byte_o == 8'h00)
    else $error("end report with nonzero payload byte");

  // Status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_status_o == sfd_pkg::ST_OK ||
      frame_status_o == sfd_pkg::ST_CRC_ERROR || frame_status_o == sfd_pkg::ST_TOO_LONG)
    else $error("undefined frame status");

endmodule

bind serial_frame_deframer_crc16_top sfd_checker u_sfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .item_kind_o     (item_kind_o),
  .payload_byte_o  (payload_byte_o),
  .frame_command_o (frame_command_o),
  .frame_length_o  (frame_length_o),
  .frame_status_o  (frame_status_o)
);

// ----- tb/sv/serial_frame_deframer_crc16_checker.sv -----
// Checker for the frame deframer: predicts payload and end-of-frame requests and compares them.
module serial_frame_deframer_crc16_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         item_kind_i,
  input  logic [7:0]                   payload_byte_i,
  input  logic [7:0]                   frame_command_i,
  input  logic [15:0]                  frame_length_i,
  input  logic [1:0]                   frame_status_i,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  pending_cnt_o,
  output int unsigned                  payload_cnt_o,
  output int unsigned                  ok_cnt_o,
  output int unsigned                  crc_err_cnt_o,
  output int unsigned                  too_long_cnt_o,
  output int unsigned                  stall_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int unsigned ShowLimit = 10;

  // Local copy of the registers
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [15:0] len_limit;

  // Parser state
  phase_e      parse_ph;
  logic [7:0]  cmd_q;
  logic [15:0] len_q;
  logic [15:0] cnt_q;
  logic [15:0] crc_q;
  logic [7:0]  crc_lo_q;

  // Requests the block still owes, oldest first
  res_t        deframed_q[$];

  int unsigned mismatch_cnt;
  int unsigned payload_cnt;
  int unsigned ok_cnt;
  int unsigned crc_err_cnt;
  int unsigned too_long_cnt;
  int unsigned stall_cnt;

  // Shift one byte through the reflected CRC register, LSB first
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void restart_hunt();
    parse_ph = PH_HUNT_FIRST;
    cmd_q    = '0;
    len_q    = '0;
    cnt_q    = '0;
    crc_q    = CRC_INIT;
    crc_lo_q = '0;
  endfunction

  function automatic void owe_request(input logic kind, input logic [7:0] data,
                                      input status_e st);
    res_t r;
    r.item_kind     = kind;
    r.payload_byte  = data;
    r.frame_command = cmd_q;
    r.frame_length  = len_q;
    r.frame_status  = st;
    deframed_q.push_back(r);
  endfunction

  // Advance the parser by one received byte
  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0] got;
    case (parse_ph)
      PH_HUNT_FIRST: begin
        if (b == hdr_first) parse_ph = PH_HUNT_SECOND;
      end
      PH_HUNT_SECOND: begin
        if (b == hdr_second) parse_ph = PH_COMMAND;
        else restart_hunt();
      end
      PH_COMMAND: begin
        cmd_q    = b;
        crc_q    = crc16_fold(CRC_INIT, b);
        parse_ph = PH_LEN_LOW;
      end
      PH_LEN_LOW: begin
        len_q    = {8'h00, b};
        crc_q    = crc16_fold(crc_q, b);
        parse_ph = PH_LEN_HIGH;
      end
      PH_LEN_HIGH: begin
        len_q = {b, len_q[7:0]};
        crc_q = crc16_fold(crc_q, b);
        if (len_q > len_limit) begin
          owe_request(KIND_END, 8'h00, ST_TOO_LONG);
          restart_hunt();
        end else begin
          cnt_q    = '0;
          parse_ph = (len_q == 16'h0000) ? PH_CRC_LOW : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_q = crc16_fold(crc_q, b);
        owe_request(KIND_PAYLOAD, b, ST_OK);
        cnt_q = cnt_q + 16'd1;
        if (cnt_q >= len_q) parse_ph = PH_CRC_LOW;
      end
      PH_CRC_LOW: begin
        crc_lo_q = b;
        parse_ph = PH_CRC_HIGH;
      end
      default: begin
        got = {b, crc_lo_q};
        if (got == crc_q) owe_request(KIND_END, 8'h00, ST_OK);
        else owe_request(KIND_END, 8'h00, ST_CRC_ERROR);
        restart_hunt();
      end
    endcase
  endfunction

  // Compare one delivered request with the oldest one owed
  function automatic void check_request();
    res_t seen;
    res_t want;
    seen.item_kind     = item_kind_i;
    seen.payload_byte  = payload_byte_i;
    seen.frame_command = frame_command_i;
    seen.frame_length  = frame_length_i;
    seen.frame_status  = status_e'(frame_status_i);
    if (deframed_q.size() == 0) begin
      if (mismatch_cnt < ShowLimit) begin
        $display("%0t: unexpected request kind %0d byte %02h cmd %02h len %04h status %0d",
                 $realtime, seen.item_kind, seen.payload_byte, seen.frame_command,
                 seen.frame_length, seen.frame_status);
      end
      mismatch_cnt++;
    end else begin
      want = deframed_q.pop_front();
      if (seen !== want) begin
        if (mismatch_cnt < ShowLimit) begin
          $display("%0t: mismatch expected kind %0d byte %02h cmd %02h len %04h status %0d",
                   $realtime, want.item_kind, want.payload_byte, want.frame_command,
                   want.frame_length, want.frame_status);
          $display("%0t:          got      kind %0d byte %02h cmd %02h len %04h status %0d",
                   $realtime, seen.item_kind, seen.payload_byte, seen.frame_command,
                   seen.frame_length, seen.frame_status);
        end
        mismatch_cnt++;
      end
      if (want.item_kind == KIND_PAYLOAD) payload_cnt++;
      else begin
        case (want.frame_status)
          ST_OK:        ok_cnt++;
          ST_CRC_ERROR: crc_err_cnt++;
          default:      too_long_cnt++;
        endcase
      end
    end
  endfunction

  // Track registers, predict on every accepted byte, check every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first  = SYNC_FIRST_RST;
      hdr_second = SYNC_SECOND_RST;
      len_limit  = MAX_LEN_RST;
      restart_hunt();
      deframed_q.delete();
      mismatch_cnt = 0;
      payload_cnt  = 0;
      ok_cnt       = 0;
      crc_err_cnt  = 0;
      too_long_cnt = 0;
      stall_cnt    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SYNC_FIRST:  hdr_first  = cfg_data_i[7:0];
          CFG_SYNC_SECOND: hdr_second = cfg_data_i[7:0];
          CFG_MAX_LEN:     len_limit  = cfg_data_i[15:0];
          default: ;
        endcase
      end
      // Check output before predicting so a fresh byte never meets its own request
      if (out_valid_i && !out_stall_i) check_request();
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
      if (in_valid_i && in_stall_i) stall_cnt++;
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_cnt_o  <= deframed_q.size();
    payload_cnt_o  <= payload_cnt;
    ok_cnt_o       <= ok_cnt;
    crc_err_cnt_o  <= crc_err_cnt;
    too_long_cnt_o <= too_long_cnt;
    stall_cnt_o    <= stall_cnt;
  end

endmodule

// ----- tb/sv/serial_frame_deframer_crc16_top_tb.sv -----
// Testbench top for the frame deframer: clock, reset, byte stream, register writes and verdict.
module serial_frame_deframer_crc16_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int unsigned BytesPerSetting = 300;
  localparam int unsigned LongHoldCycles  = 200;
  localparam int unsigned HoldFrameLen    = 250;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                item_kind_o;
  logic [7:0]          payload_byte_o;
  logic [7:0]          frame_command_o;
  logic [15:0]         frame_length_o;
  logic [1:0]          frame_status_o;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned payload_cnt;
  int unsigned ok_cnt;
  int unsigned crc_err_cnt;
  int unsigned too_long_cnt;
  int unsigned stall_cnt;

  // Traffic shaping
  int unsigned tx_idle_pct  = 27;
  int unsigned rx_stall_pct = 48;
  int unsigned hold_left    = 0;
  logic        hold_go      = 1'b0;
  logic        hold_done    = 1'b0;

  // Register values the stream is built for
  logic [7:0]  cur_first  = SYNC_FIRST_RST;
  logic [7:0]  cur_second = SYNC_SECOND_RST;
  logic [15:0] cur_max    = MAX_LEN_RST;
  int unsigned bytes_sent = 0;

  serial_frame_deframer_crc16_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_o     (item_kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o),
    .frame_status_o  (frame_status_o)
  );

  serial_frame_deframer_crc16_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_i     (item_kind_o),
    .payload_byte_i  (payload_byte_o),
    .frame_command_i (frame_command_o),
    .frame_length_i  (frame_length_o),
    .frame_status_i  (frame_status_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_cnt_o   (pending_cnt),
    .payload_cnt_o   (payload_cnt),
    .ok_cnt_o        (ok_cnt),
    .crc_err_cnt_o   (crc_err_cnt),
    .too_long_cnt_o  (too_long_cnt),
    .stall_cnt_o     (stall_cnt)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= LongHoldCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Offer one byte after random idle cycles and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Write enable stays high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_SYNC_FIRST:  cur_first  = data[7:0];
      CFG_SYNC_SECOND: cur_second = data[7:0];
      CFG_MAX_LEN:     cur_max    = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop sending, collect every owed request, then let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int n = 0; n < 20000 && pending_cnt != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Send one frame; fill below zero means random payload. Too long frames end at the length.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input logic [15:0] crc_flip, input int fill);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    send_byte(cur_first);
    send_byte(cur_second);
    send_byte(cmd);
    crc = crc_update(crc, cmd);
    send_byte(len[7:0]);
    crc = crc_update(crc, len[7:0]);
    send_byte(len[15:8]);
    crc = crc_update(crc, len[15:8]);
    if (len <= cur_max) begin
      for (int i = 0; i < int'(len); i++) begin
        b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
        send_byte(b);
        crc = crc_update(crc, b);
      end
      crc = crc ^ crc_flip;
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
    end
  endtask

  // Mostly good frames with random content; some too long, broken headers and noise
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned cap;
    int unsigned n;
    logic [15:0] len;
    logic [15:0] flip;
    pick = $urandom_range(99);
    cap  = (cur_max < 24) ? cur_max : 24;
    flip = ($urandom_range(4) == 0) ? 16'(1 << $urandom_range(15)) : 16'h0000;
    if (pick < 70 || (pick < 80 && cur_max == 16'hFFFF)) begin
      case ($urandom_range(9))
        0:       len = 16'h0000;
        1:       len = (cur_max <= 64) ? cur_max : 16'($urandom_range(cap));
        default: len = 16'($urandom_range(cap));
      endcase
      send_frame(8'($urandom_range(255)), len, flip, -1);
    end else if (pick < 80) begin
      case ($urandom_range(2))
        0:       len = cur_max + 16'd1;
        1:       len = 16'hFFFF;
        default: len = 16'($urandom_range(65535, cur_max + 1));
      endcase
      send_frame(8'($urandom_range(255)), len, 16'h0000, -1);
    end else if (pick < 90) begin
      send_byte(cur_first);
      send_byte(cur_second ^ 8'($urandom_range(255, 1)));
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Reprogram all registers while idle, then stream random traffic
  task automatic run_setting(input logic [7:0] first, input logic [7:0] second,
                             input logic [15:0] max_len, input int unsigned tx_pct,
                             input int unsigned rx_pct, input logic long_hold);
    int unsigned stop_at;
    wait_idle();
    write_reg(CFG_SYNC_FIRST, {8'h00, first});
    write_reg(CFG_SYNC_SECOND, {8'h00, second});
    write_reg(CFG_MAX_LEN, max_len);
    cfg_we_i     <= 1'b0;
    tx_idle_pct   = tx_pct;
    rx_stall_pct <= rx_pct;
    stop_at       = bytes_sent + BytesPerSetting;
    if (long_hold) begin
      hold_go <= 1'b1;
      send_frame(8'($urandom_range(255)), 16'(HoldFrameLen), 16'h0000, -1);
    end
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty frame with good CRC, extreme command
    send_frame(8'hFF, 16'h0000, 16'h0000, -1);
    // Wrong second header; that byte must not count as a first header
    send_byte(cur_first);
    send_byte(cur_first);
    send_byte(cur_second);
    // Limit changed mid-frame, then a maximal length that exceeds it
    send_byte(cur_first);
    send_byte(cur_second);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
    write_reg(CFG_MAX_LEN, 16'hFFFE);
    cfg_we_i <= 1'b0;
    send_byte(8'hFF);
    // One zero payload byte followed by a bad CRC
    send_frame(8'h80, 16'h0001, 16'h8000, 0);

    // Random traffic over several register settings and idle profiles
    run_setting(8'hAA, 8'h55, 16'd1024, 27, 48, 1'b0);
    run_setting(8'h00, 8'hFF, 16'd0, 27, 48, 1'b0);
    run_setting(8'hFF, 8'h00, 16'hFFFF, 48, 27, 1'b0);
    run_setting(8'h5A, 8'h5A, 16'd7, 48, 27, 1'b0);
    run_setting(8'h3C, 8'hC3, 16'd300, 0, 0, 1'b1);
    wait_idle();

    $display("Sent %0d bytes over five register settings and three idle profiles, %s",
             bytes_sent, "including one long output hold-off.");
    $display("Checked %0d payload bytes and %0d ok, %0d crc_error, %0d too_long reports; %s %0d.",
             payload_cnt, ok_cnt, crc_err_cnt, too_long_cnt, "input stall cycles", stall_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d requests never delivered", mismatch_cnt, pending_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("Run timed out");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- serial_frame_deframer_crc16_top.f -----
design/sfd_pkg.sv
design/sfd_cfg_regs.sv
design/sfd_parser.sv
design/serial_frame_deframer_crc16_top.sv
design/sfd_checker.sv
tb/sv/serial_frame_deframer_crc16_checker.sv
tb/sv/serial_frame_deframer_crc16_top_tb.sv
